// ===== hdl/vpr_pkg.sv =====
// ----------------------------------------------------------------------------
// vpr_pkg: shared definitions for the video packet receiver
// Defaults, result codes, handshake structs between the parser and the
// frame buffer, and the CCITT CRC byte update.
// ----------------------------------------------------------------------------
package vpr_pkg;

    // default geometry
    localparam int LINE_PIXELS_DEF = 80;
    localparam int FRAME_LINES_DEF = 60;
    // header length is fixed by the packet format
    localparam int HEADER_BYTES    = 4;

    // pixel and line indexes never exceed 255 in the supported geometry range
    localparam int IDX_W = 8;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    // result codes
    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_DISCARD = 3'd1;
    localparam logic [2:0] EV_LINE    = 3'd2;
    localparam logic [2:0] EV_FRAME   = 3'd3;
    localparam logic [2:0] EV_CRC     = 3'd4;
    localparam logic [2:0] EV_BADHDR  = 3'd5;

    // one word into the line staging buffer
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] px;
        logic [15:0]      data;
    } t_stage_wr;

    // staged line is good: copy it to the frame store
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] line;
    } t_commit;

    // frame store read request, issued when an item moves to the result stage
    typedef struct packed {
        logic        en;
        logic        fetch;
        logic [12:0] addr;
    } t_rd_req;

    // status fields of one result item
    typedef struct packed {
        logic [2:0]  ev;
        logic [5:0]  lines;
        logic [15:0] disc;
    } t_fsm_res;

    // CCITT CRC, MSB first, one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] x;
        x = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            x = x[15] ? ({x[14:0], 1'b0} ^ CRC_POLY) : {x[14:0], 1'b0};
        end
        return x;
    endfunction

endpackage

// ===== hdl/vpr_packet_fsm.sv =====
// ----------------------------------------------------------------------------
// vpr_packet_fsm: link byte parser
// Hunts for sync, skips discard packets, checks headers and CRC, stages
// pixel words and requests a line commit on a good packet.
// ----------------------------------------------------------------------------
module vpr_packet_fsm #(
    parameter int LINE_PIXELS = 80,
    parameter int FRAME_LINES = 60
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_byte,
    output vpr_pkg::t_fsm_res   o_res,
    output vpr_pkg::t_stage_wr  o_stage_wr,
    output vpr_pkg::t_commit    o_commit
);
    import vpr_pkg::*;

    localparam int PKT_BYTES = HEADER_BYTES + 2 * LINE_PIXELS;
    localparam int PBW       = $clog2(PKT_BYTES);
    localparam int LW        = $clog2(FRAME_LINES);

    localparam logic [2:0] PH_HUNT1 = 3'd0;
    localparam logic [2:0] PH_HUNT2 = 3'd1;
    localparam logic [2:0] PH_SKIP  = 3'd2;
    localparam logic [2:0] PH_HDR   = 3'd3;
    localparam logic [2:0] PH_LINE  = 3'd4;

    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_VIDEO   = 2'd1;
    localparam logic [1:0] KIND_DISCARD = 2'd2;
    localparam logic [1:0] KIND_BAD     = 2'd3;

    logic [2:0]     r_phase, n_phase;
    logic [PBW-1:0] r_pos,   n_pos;
    logic [15:0]    r_crc,   n_crc;
    logic [15:0]    r_rcv,   n_rcv;
    logic [1:0]     r_kind,  n_kind;
    logic [LW-1:0]  r_line,  n_line;
    logic [15:0]    r_disc,  n_disc;
    logic [7:0]     r_hi,    n_hi;

    logic [PBW:0]   pos_inc;
    logic [PBW-1:0] off;
    logic [LW:0]    line_inc;
    logic [7:0]     eff;
    logic [15:0]    crc_out;
    logic [2:0]     ev;
    logic [8:0]     lines9;

    // next state for one link byte
    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_crc      = r_crc;
        n_rcv      = r_rcv;
        n_kind     = r_kind;
        n_line     = r_line;
        n_disc     = r_disc;
        n_hi       = r_hi;
        ev         = EV_NONE;
        o_stage_wr = '0;
        o_commit   = '0;
        pos_inc    = {1'b0, r_pos} + 1'b1;
        off        = r_pos - PBW'(HEADER_BYTES);
        line_inc   = {1'b0, r_line} + 1'b1;
        eff        = i_byte;
        crc_out    = '0;

        if (i_step) begin
            case (r_phase)
                PH_HUNT2: begin
                    if (i_byte[7:4] == 4'hF) begin
                        n_phase = PH_SKIP;
                        n_pos   = PBW'(2);
                    end else begin
                        n_phase = PH_HUNT1;
                    end
                end
                PH_SKIP: begin
                    n_pos = pos_inc[PBW-1:0];
                    if (pos_inc >= (PBW+1)'(PKT_BYTES)) begin
                        n_pos   = '0;
                        n_disc  = r_disc + 16'd1;
                        n_line  = '0;
                        n_phase = PH_HDR;
                        ev      = EV_DISCARD;
                    end
                end
                PH_HDR, PH_LINE: begin
                    // header classification
                    if (r_pos == '0) begin
                        if (r_phase == PH_LINE)         n_kind = KIND_VIDEO;
                        else if (i_byte[3:0] == 4'h0)   n_kind = KIND_VIDEO;
                        else if (i_byte[3:0] == 4'hF)   n_kind = KIND_DISCARD;
                        else                            n_kind = KIND_BAD;
                    end else if (r_pos == PBW'(1) && r_phase == PH_HDR) begin
                        if (r_kind == KIND_VIDEO && i_byte != 8'(r_line))
                            n_kind = KIND_BAD;
                        else if (r_kind == KIND_DISCARD && i_byte[7:4] != 4'hF)
                            n_kind = KIND_BAD;
                    end

                    // ID and CRC bytes count as zero in the CRC
                    if (r_pos == '0 || r_pos == PBW'(2) || r_pos == PBW'(3))
                        eff = 8'h00;
                    if (r_pos == PBW'(2)) n_rcv = {i_byte, 8'h00};
                    if (r_pos == PBW'(3)) n_rcv = {r_rcv[15:8], i_byte};
                    crc_out = crc_byte((r_pos == '0) ? 16'h0000 : r_crc, eff);

                    // payload: high byte held, word written on the low byte
                    if (r_pos >= PBW'(HEADER_BYTES)) begin
                        if (!off[0]) begin
                            n_hi = i_byte;
                        end else begin
                            o_stage_wr.we   = 1'b1;
                            o_stage_wr.px   = IDX_W'(off >> 1);
                            o_stage_wr.data = {r_hi, i_byte};
                        end
                    end

                    if (pos_inc < (PBW+1)'(PKT_BYTES)) begin
                        n_pos = pos_inc[PBW-1:0];
                        n_crc = crc_out;
                    end else begin
                        // end of packet
                        n_pos = '0;
                        n_crc = '0;
                        if (n_kind == KIND_DISCARD) begin
                            n_disc = r_disc + 16'd1;
                            ev     = EV_DISCARD;
                        end else if (n_kind == KIND_BAD) begin
                            n_phase = PH_HUNT1;
                            ev      = EV_BADHDR;
                        end else if (crc_out != n_rcv) begin
                            n_phase = PH_HUNT1;
                            ev      = EV_CRC;
                        end else begin
                            o_commit.valid = 1'b1;
                            o_commit.line  = IDX_W'(r_line);
                            if (line_inc >= (LW+1)'(FRAME_LINES)) begin
                                n_line  = '0;
                                n_phase = PH_HDR;
                                ev      = EV_FRAME;
                            end else begin
                                n_line  = line_inc[LW-1:0];
                                n_phase = PH_LINE;
                                ev      = EV_LINE;
                            end
                        end
                    end
                end
                default: begin
                    n_pos   = '0;
                    n_phase = (i_byte[3:0] == 4'hF) ? PH_HUNT2 : PH_HUNT1;
                end
            endcase
        end

        lines9      = (ev == EV_FRAME) ? 9'(FRAME_LINES) : 9'(n_line);
        o_res.ev    = ev;
        o_res.lines = lines9[5:0];
        o_res.disc  = n_disc;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT1;
            r_pos   <= '0;
            r_crc   <= '0;
            r_rcv   <= '0;
            r_kind  <= KIND_NONE;
            r_line  <= '0;
            r_disc  <= '0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_crc   <= n_crc;
            r_rcv   <= n_rcv;
            r_kind  <= n_kind;
            r_line  <= n_line;
            r_disc  <= n_disc;
        end
    end

    // held high byte of a pixel
    always_ff @(posedge i_clk) begin
        r_hi <= n_hi;
    end

`ifndef ASSERT_OFF
    // a discard result always bumps the counter by one
    a_disc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res.ev == EV_DISCARD) |=> (r_disc == $past(r_disc) + 16'd1))
        else $error("discard counter not advanced");
`endif

endmodule

// ===== hdl/vpr_frame_buf.sv =====
// ----------------------------------------------------------------------------
// vpr_frame_buf: line staging buffer and frame store
// A committed line is copied from staging to the frame store in the
// background, one word a cycle; reads of words not yet copied are served
// from staging.
// ----------------------------------------------------------------------------
module vpr_frame_buf #(
    parameter int LINE_PIXELS = 80,
    parameter int FRAME_LINES = 60
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vpr_pkg::t_stage_wr  i_stage_wr,
    input  vpr_pkg::t_commit    i_commit,
    input  vpr_pkg::t_rd_req    i_rd,
    output logic [15:0]         o_pixel
);
    import vpr_pkg::*;

    localparam int FP  = LINE_PIXELS * FRAME_LINES;
    localparam int FAW = $clog2(FP);
    localparam int PW  = $clog2(LINE_PIXELS);
    localparam int EW  = ((FAW > 13) ? FAW : 13) + 1;

    logic [15:0]    r_stage [LINE_PIXELS];
    logic [15:0]    r_frame [FP];

    logic           r_cp_rd_act;
    logic [PW-1:0]  r_cp_rd;
    logic           r_cp_wv;
    logic [PW-1:0]  r_cp_widx;
    logic [FAW-1:0] r_cp_base;
    logic [15:0]    r_cp_q;

    logic [15:0]    r_fr_q;
    logic [15:0]    r_byp_q;
    logic           r_sel_byp;
    logic           r_sel_zero;

    logic [EW-1:0]  addr_ext;
    logic [EW-1:0]  base_ext;
    logic [EW-1:0]  off_ext;
    logic [PW-1:0]  off_idx;
    logic [PW-1:0]  thr;
    logic [FAW+12:0] addr_wide;
    logic [FAW-1:0] rd_idx;
    logic           in_range;
    logic           in_line;
    logic           cp_busy;
    logic           byp;

    // read address decode and staging bypass
    always_comb begin
        addr_ext  = EW'(i_rd.addr);
        base_ext  = EW'(r_cp_base);
        off_ext   = addr_ext - base_ext;
        off_idx   = off_ext[PW-1:0];
        addr_wide = {{FAW{1'b0}}, i_rd.addr};
        rd_idx    = addr_wide[FAW-1:0];
        in_range  = addr_ext < EW'(FP);
        in_line   = (addr_ext >= base_ext) && (off_ext < EW'(LINE_PIXELS));
        cp_busy   = r_cp_rd_act || r_cp_wv;
        thr       = r_cp_wv ? r_cp_widx : r_cp_rd;
        byp       = in_line && cp_busy && (off_idx >= thr);
    end

    // staging memory: one write, copy read and bypass read
    always_ff @(posedge i_clk) begin
        if (i_stage_wr.we)
            r_stage[i_stage_wr.px[PW-1:0]] <= i_stage_wr.data;
        r_cp_q <= r_stage[r_cp_rd];
        if (i_rd.en && i_rd.fetch && byp)
            r_byp_q <= r_stage[off_idx];
    end

    // frame memory: copy write and item read
    always_ff @(posedge i_clk) begin
        if (r_cp_wv)
            r_frame[r_cp_base + FAW'(r_cp_widx)] <= r_cp_q;
        if (i_rd.en && i_rd.fetch && in_range)
            r_fr_q <= r_frame[rd_idx];
    end

    // copy sequencer and read select
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cp_rd_act <= 1'b0;
            r_cp_rd     <= '0;
            r_cp_wv     <= 1'b0;
            r_cp_widx   <= '0;
            r_cp_base   <= '0;
            r_sel_byp   <= 1'b0;
            r_sel_zero  <= 1'b1;
        end else begin
            if (i_commit.valid) begin
                r_cp_base   <= FAW'(FAW'(i_commit.line) * FAW'(LINE_PIXELS));
                r_cp_rd     <= '0;
                r_cp_rd_act <= 1'b1;
                r_cp_wv     <= 1'b0;
            end else begin
                r_cp_wv   <= r_cp_rd_act;
                r_cp_widx <= r_cp_rd;
                if (r_cp_rd_act) begin
                    if (r_cp_rd == PW'(LINE_PIXELS - 1))
                        r_cp_rd_act <= 1'b0;
                    else
                        r_cp_rd <= r_cp_rd + 1'b1;
                end
            end
            if (i_rd.en) begin
                r_sel_zero <= !(i_rd.fetch && in_range);
                r_sel_byp  <= byp;
            end
        end
    end

    assign o_pixel = r_sel_zero ? 16'h0000 : (r_sel_byp ? r_byp_q : r_fr_q);

`ifndef ASSERT_OFF
    // a new line may only arrive once the previous copy has drained
    a_commit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_commit.valid |-> !cp_busy)
        else $error("line commit during copy");

    // the copy write trails the copy read by one word
    a_copy_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cp_rd_act && !i_commit.valid) |=> (r_cp_wv && r_cp_widx == $past(r_cp_rd)))
        else $error("copy write out of step");
`endif

endmodule

// ===== hdl/vospi_packet_receiver.sv =====
// ----------------------------------------------------------------------------
// vospi_packet_receiver: video packet receiver with frame store
// Top level: input register, parser, frame buffer and result register.
// ----------------------------------------------------------------------------
// Takes one item per clock while the output is not stalled: a link byte
// (func 0) or a frame store read (func 1). Each input item gives one
// result item, which passes through the input register and then the
// result register before it is presented. The input register and the
// result register each hold one item, so one further item is taken while a
// result waits. The CRC, header and line logic all sit between those two
// registers. A good line is copied from the staging buffer into the frame
// store by a background sequencer, one pixel a cycle; reads that land on
// pixels not yet copied are answered from staging, so the copy never holds
// up input. No clearing pass after reset: frame store pixels never written
// read back undefined.
module vospi_packet_receiver #(
    parameter int LINE_PIXELS = vpr_pkg::LINE_PIXELS_DEF,
    parameter int FRAME_LINES = vpr_pkg::FRAME_LINES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_func,
    input  logic [7:0]  i_rx_byte,
    input  logic [12:0] i_read_addr,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_event_res,
    output logic [5:0]  o_lines_done,
    output logic [15:0] o_discard_total,
    output logic [15:0] o_pixel_data
);
    import vpr_pkg::*;

    logic        r_s1_valid;
    logic        r_s1_func;
    logic [7:0]  r_s1_byte;
    logic [12:0] r_s1_addr;
    logic        r_out_valid;
    t_fsm_res    r_res;

    logic        adv;
    logic        load;
    t_fsm_res    fsm_res;
    t_stage_wr   stage_wr;
    t_commit     commit;
    t_rd_req     rd_req;

    // handshake: the item in the input register moves on when the result
    // register is free or being emptied
    assign adv     = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || adv;
    assign load    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load)
                r_s1_valid <= 1'b1;
            else if (adv)
                r_s1_valid <= 1'b0;
            if (adv)
                r_out_valid <= 1'b1;
            else if (i_ready)
                r_out_valid <= 1'b0;
        end
    end

    // item payload and result fields
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_s1_func <= i_func;
            r_s1_byte <= i_rx_byte;
            r_s1_addr <= i_read_addr;
        end
        if (adv)
            r_res <= fsm_res;
    end

    vpr_packet_fsm #(
        .LINE_PIXELS (LINE_PIXELS),
        .FRAME_LINES (FRAME_LINES)
    ) u_fsm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (adv && !r_s1_func),
        .i_byte     (r_s1_byte),
        .o_res      (fsm_res),
        .o_stage_wr (stage_wr),
        .o_commit   (commit)
    );

    assign rd_req.en    = adv;
    assign rd_req.fetch = r_s1_func;
    assign rd_req.addr  = r_s1_addr;

    vpr_frame_buf #(
        .LINE_PIXELS (LINE_PIXELS),
        .FRAME_LINES (FRAME_LINES)
    ) u_frame (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_stage_wr (stage_wr),
        .i_commit   (commit),
        .i_rd       (rd_req),
        .o_pixel    (o_pixel_data)
    );

    assign o_valid         = r_out_valid;
    assign o_event_res     = r_res.ev;
    assign o_lines_done    = r_res.lines;
    assign o_discard_total = r_res.disc;

`ifndef ASSERT_OFF
    // byte items never carry pixel data
    a_event_no_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_event_res != EV_NONE) |-> (o_pixel_data == 16'h0000))
        else $error("pixel data on a byte result");

    // frame complete reports the full line count
    a_frame_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_event_res == EV_FRAME) |-> (o_lines_done == 6'(FRAME_LINES)))
        else $error("frame complete with wrong line count");
`endif

endmodule
